FILE: rtl/sorted_store_interpolation_search_top_assert.svh
// Assertion macros for the sorted store top level.
// Depends on a clock named clk and a reset named rst in the including scope.
`ifndef SORTED_STORE_INTERPOLATION_SEARCH_TOP_ASSERT_SVH
`define SORTED_STORE_INTERPOLATION_SEARCH_TOP_ASSERT_SVH

// Check a property outside of reset.
`define SSIS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sorted store check failed");

// Check a property on every edge, reset included.
`define SSIS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("sorted store check failed");

`endif

FILE: rtl/ssis_pkg.sv
// Shared types and codes for the sorted store with interpolation search.
// No dependencies.
package ssis_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;

  localparam int FIELD_BITS = 11;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_INS_RD, DP_INS_SHIFT, DP_INS_PUT, DP_CLEAR,
    DP_RD_LO, DP_RD_HI, DP_CAP_HI, DP_MUL, DP_DINIT, DP_DIV,
    DP_RD_PROBE, DP_CMP, DP_FIN
  } dp_op_t;

  typedef enum logic [3:0] {
    C_IDLE, C_DISPATCH, C_INS_CHK, C_INS_WAIT, C_INS_PUT, C_S_TOP, C_S_LOW,
    C_S_HIGH, C_S_COND, C_S_DINIT, C_S_DIV, C_S_PROBE, C_S_CMP, C_FIN
  } ctl_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] code;
    logic       accept;
  } ssis_ctl_t;

  typedef struct packed {
    logic       req_valid;
    logic [1:0] cmd;
    logic       full;
    logic       slot_zero;
    logic       rd_gt;
    logic       lo_le_hi;
    logic       in_range;
    logic       ends_eq;
    logic       div_done;
    logic       hit;
    logic       out_busy;
  } ssis_stat_t;

endpackage

FILE: rtl/ssis_chan_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on nothing; field widths follow the block's fixed item format.
interface ssis_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] value;
  modport source (output valid, cmd, value, input ready);
  modport sink (input valid, cmd, value, output ready);
endinterface

interface ssis_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [10:0] position;
  logic [10:0] count;
  modport source (output valid, status, position, count, input ready);
  modport sink (input valid, status, position, count, output ready);
endinterface

FILE: rtl/ssis_ctrl.sv
// Sequencer for insert, search and clear transactions.
// Depends on ssis_pkg; drives the datapath through ssis_ctl_t commands.
module ssis_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  ssis_pkg::ssis_stat_t stat,
  output ssis_pkg::ssis_ctl_t  ctl
);
  import ssis_pkg::*;

  ctl_state_t state, state_next;
  logic [2:0] code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      code  <= ST_NOT_FOUND;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next = state;
    code_next  = code;
    ctl.op     = DP_NOP;
    ctl.code   = code;
    ctl.accept = 1'b0;
    case (state)
      C_IDLE: begin
        ctl.accept = 1'b1;
        if (stat.req_valid) begin
          ctl.op     = DP_LOAD;
          state_next = C_DISPATCH;
        end
      end
      C_DISPATCH: begin
        case (stat.cmd)
          CMD_INSERT: begin
            if (stat.full) begin
              code_next  = ST_FULL;
              state_next = C_FIN;
            end else begin
              state_next = C_INS_CHK;
            end
          end
          CMD_SEARCH: state_next = C_S_TOP;
          CMD_CLEAR: begin
            ctl.op     = DP_CLEAR;
            code_next  = ST_CLEARED;
            state_next = C_FIN;
          end
          default: begin
            code_next  = ST_NOT_FOUND;
            state_next = C_FIN;
          end
        endcase
      end
      C_INS_CHK: begin
        if (stat.slot_zero) begin
          state_next = C_INS_PUT;
        end else begin
          ctl.op     = DP_INS_RD;
          state_next = C_INS_WAIT;
        end
      end
      C_INS_WAIT: begin
        if (stat.rd_gt) begin
          ctl.op     = DP_INS_SHIFT;
          state_next = C_INS_CHK;
        end else begin
          state_next = C_INS_PUT;
        end
      end
      C_INS_PUT: begin
        ctl.op     = DP_INS_PUT;
        code_next  = ST_INSERTED;
        state_next = C_FIN;
      end
      C_S_TOP: begin
        if (stat.lo_le_hi) begin
          ctl.op     = DP_RD_LO;
          state_next = C_S_LOW;
        end else begin
          code_next  = ST_NOT_FOUND;
          state_next = C_FIN;
        end
      end
      C_S_LOW: begin
        ctl.op     = DP_RD_HI;
        state_next = C_S_HIGH;
      end
      C_S_HIGH: begin
        ctl.op     = DP_CAP_HI;
        state_next = C_S_COND;
      end
      C_S_COND: begin
        if (!stat.in_range) begin
          code_next  = ST_NOT_FOUND;
          state_next = C_FIN;
        end else if (stat.ends_eq) begin
          state_next = C_S_PROBE;
        end else begin
          ctl.op     = DP_MUL;
          state_next = C_S_DINIT;
        end
      end
      C_S_DINIT: begin
        ctl.op     = DP_DINIT;
        state_next = C_S_DIV;
      end
      C_S_DIV: begin
        if (stat.div_done) begin
          state_next = C_S_PROBE;
        end else begin
          ctl.op = DP_DIV;
        end
      end
      C_S_PROBE: begin
        ctl.op     = DP_RD_PROBE;
        state_next = C_S_CMP;
      end
      C_S_CMP: begin
        ctl.op = DP_CMP;
        if (stat.hit) begin
          code_next  = ST_FOUND;
          state_next = C_FIN;
        end else begin
          state_next = C_S_TOP;
        end
      end
      C_FIN: begin
        if (!stat.out_busy) begin
          ctl.op     = DP_FIN;
          state_next = C_IDLE;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

endmodule

FILE: rtl/ssis_dp.sv
// Datapath: value memory, search bounds, multiplier, serial divider, result register.
// Depends on ssis_pkg and the channel interfaces in ssis_chan_if.sv.
module ssis_dp #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ssis_pkg::ssis_ctl_t  ctl,
  output ssis_pkg::ssis_stat_t stat,
  ssis_req_if.sink             req,
  ssis_rsp_if.source           rsp
);
  import ssis_pkg::*;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SW  = CW + 1;
  localparam int NB  = CW + VALUE_BITS;
  localparam int DCW = $clog2(NB + 1);

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rdata;
  logic [VALUE_BITS-1:0] key, vlo, vhi, dvs;
  logic [1:0]            cmd;
  logic [CW-1:0]         count, slot, pos;
  logic signed [SW-1:0]  lo, hi;
  logic [AW-1:0]         probe;
  logic [NB-1:0]         quo;
  logic [VALUE_BITS:0]   rem;
  logic [DCW-1:0]        dcnt;

  logic                  rd_en, we;
  logic [AW-1:0]         raddr, waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic [AW-1:0]         probe_next;
  logic signed [SW-1:0]  probe_s;
  logic [VALUE_BITS:0]   rem_sh;
  logic                  qbit;

  assign req.ready = ctl.accept;

  assign probe_next = (vhi == vlo) ? lo[AW-1:0] : AW'(lo[AW-1:0] + quo[AW-1:0]);
  assign probe_s    = signed'({{(SW - AW){1'b0}}, probe});
  assign rem_sh     = {rem[VALUE_BITS-1:0], quo[NB-1]};
  assign qbit       = rem_sh >= {1'b0, dvs};

  always_comb begin
    rd_en = 1'b0;
    raddr = lo[AW-1:0];
    we    = 1'b0;
    waddr = slot[AW-1:0];
    wdata = key;
    case (ctl.op)
      DP_INS_RD: begin
        rd_en = 1'b1;
        raddr = AW'(slot - CW'(1));
      end
      DP_INS_SHIFT: begin
        we    = 1'b1;
        wdata = rdata;
      end
      DP_INS_PUT: we = 1'b1;
      DP_RD_LO:   rd_en = 1'b1;
      DP_RD_HI: begin
        rd_en = 1'b1;
        raddr = hi[AW-1:0];
      end
      DP_RD_PROBE: begin
        rd_en = 1'b1;
        raddr = probe_next;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      case (ctl.op)
        DP_INS_PUT: count <= count + CW'(1);
        DP_CLEAR:   count <= '0;
        default:    count <= count;
      endcase
      if (ctl.op == DP_FIN) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      DP_LOAD: begin
        cmd  <= req.cmd;
        key  <= VALUE_BITS'(req.value);
        slot <= count;
        lo   <= '0;
        hi   <= signed'({1'b0, count}) - SW'(1);
        pos  <= '0;
      end
      DP_INS_SHIFT: slot <= slot - CW'(1);
      DP_RD_HI:     vlo <= rdata;
      DP_CAP_HI:    vhi <= rdata;
      DP_MUL: begin
        // span times key offset; becomes the dividend
        quo <= NB'(CW'(hi - lo)) * NB'(key - vlo);
        dvs <= vhi - vlo;
      end
      DP_DINIT: begin
        rem  <= '0;
        dcnt <= DCW'(NB);
      end
      DP_DIV: begin
        rem  <= qbit ? rem_sh - {1'b0, dvs} : rem_sh;
        quo  <= {quo[NB-2:0], qbit};
        dcnt <= dcnt - DCW'(1);
      end
      DP_RD_PROBE: probe <= probe_next;
      DP_CMP: begin
        if (rdata == key) begin
          pos <= CW'(probe) + CW'(1);
        end else if (rdata < key) begin
          lo <= probe_s + SW'(1);
        end else begin
          hi <= probe_s - SW'(1);
        end
      end
      DP_FIN: begin
        rsp.status   <= ctl.code;
        rsp.position <= FIELD_BITS'(pos);
        rsp.count    <= FIELD_BITS'(count);
      end
      default: slot <= slot;
    endcase
  end

  always_comb begin
    stat.req_valid = req.valid;
    stat.cmd       = cmd;
    stat.full      = count == CW'(DEPTH);
    stat.slot_zero = slot == '0;
    stat.rd_gt     = rdata > key;
    stat.lo_le_hi  = lo <= hi;
    stat.in_range  = (key >= vlo) && (key <= vhi);
    stat.ends_eq   = vhi == vlo;
    stat.div_done  = dcnt == '0;
    stat.hit       = rdata == key;
    stat.out_busy  = rsp.valid && !rsp.ready;
  end

endmodule

FILE: rtl/sorted_store_interpolation_search_top.sv
// Channel   | Dir | Payload
// req       | in  | cmd[1:0], value[15:0]
// rsp       | out | status[2:0], position[10:0], count[10:0]
// One transaction at a time.
// Insert moves each larger entry up one slot (one memory read and one write each).
// Search probes until a hit, crossed bounds or a key outside the end values; each probe is set by the
// one-bit-a-cycle divider over CW + VALUE_BITS quotient bits unless both end values match; CW = clog2(DEPTH + 1).
// rst is synchronous and empties the store; the value memory is not cleared.
// A stalled rsp holds the finished result; the next req is taken meanwhile.
// Depends on ssis_pkg, ssis_chan_if.sv, ssis_ctrl, ssis_dp and the assertion header.
module sorted_store_interpolation_search_top #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  ssis_req_if.sink   req,
  ssis_rsp_if.source rsp
);
  import ssis_pkg::*;
  `include "sorted_store_interpolation_search_top_assert.svh"

  ssis_ctl_t  ctl;
  ssis_stat_t stat;

  ssis_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  ssis_dp #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

  `SSIS_ASSERT(a_one_at_a_time, (req.valid && req.ready) |=> !req.ready)
  `SSIS_ASSERT(a_pos_only_found, (rsp.valid && rsp.status != ST_FOUND) |-> rsp.position == '0)
  `SSIS_ASSERT(a_full_count, (rsp.valid && rsp.status == ST_FULL) |-> rsp.count == FIELD_BITS'(DEPTH))
  `SSIS_ASSERT(a_clear_count, (rsp.valid && rsp.status == ST_CLEARED) |-> rsp.count == '0)
  `SSIS_ASSERT_ALWAYS(a_reset_idle, rst |=> (!rsp.valid && req.ready))

endmodule
